FILE: sv/hrs_pkg.sv
package hrs_pkg;

  localparam int NUM_BINS   = 30;
  localparam int COUNT_BITS = 24;

  localparam int VAL_W   = 12;
  localparam int VSQ_W   = 2 * VAL_W;
  localparam int SUM_W   = COUNT_BITS + VAL_W;
  localparam int SQ_W    = COUNT_BITS + VSQ_W;
  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int SLOT_N  = 2 * NUM_BINS;
  localparam int SLOT_W  = $clog2(SLOT_N);
  localparam int RES_W   = 16;

  // math unit widths
  localparam int PROD_W  = COUNT_BITS + SQ_W;
  localparam int RAD_W   = PROD_W + 8;
  localparam int DIVD_W  = SUM_W + 4;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SREM_W  = ROOT_W + 1;
  localparam int CNT_W   = $clog2(DIVD_W);

  // bin classification: (v - 800) / 100 by reciprocal multiply
  localparam logic [VAL_W-1:0] BIN_BASE = VAL_W'(800);
  localparam int RECIP_W   = 13;
  localparam logic [RECIP_W-1:0] BIN_RECIP = RECIP_W'(5243);
  localparam int BIN_SHIFT = 19;
  localparam int BPROD_W   = VAL_W + RECIP_W;
  localparam int BQ_W      = BPROD_W - BIN_SHIFT;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]      SUM_MAX   = '1;
  localparam logic [SQ_W-1:0]       SQ_MAX    = '1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic              op;
    logic              cls;
    logic [BIN_W-1:0]  bin;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;
    logic [VSQ_W-1:0]  vsq;
  } hrs_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] n;
    logic [SUM_W-1:0]      sum;
    logic [SQ_W-1:0]       sumsq;
  } hrs_stats_t;

  typedef struct packed {
    logic [RES_W-1:0] mean;
    logic [RES_W-1:0] sd;
  } hrs_res_t;

endpackage

FILE: sv/hrs_ram.sv
module hrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/hrs_front.sv
module hrs_front import hrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_operation,
  input  logic             in_stat_class,
  input  logic [VAL_W-1:0] in_sample_value,
  input  logic             q_full,
  output logic             q_push,
  output hrs_item_t        q_item
);

  logic              f_valid_r;
  hrs_item_t         f_item_r;
  hrs_item_t         item_nxt;
  logic [VAL_W-1:0]  diff;
  logic [BPROD_W-1:0] bprod;
  logic [BQ_W-1:0]   bq;
  logic [BIN_W-1:0]  bin;
  logic              accept;

  // bin from value, clamped at both ends
  always_comb begin
    diff  = (in_sample_value < BIN_BASE) ? '0 : in_sample_value - BIN_BASE;
    bprod = BPROD_W'(diff) * BPROD_W'(BIN_RECIP);
    bq    = bprod[BPROD_W-1:BIN_SHIFT];
    bin   = (bq > BQ_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : BIN_W'(bq);
    item_nxt.op    = in_operation;
    item_nxt.cls   = in_stat_class;
    item_nxt.bin   = bin;
    item_nxt.slot  = in_stat_class ? SLOT_W'(NUM_BINS) + SLOT_W'(bin) : SLOT_W'(bin);
    item_nxt.value = in_sample_value;
    item_nxt.vsq   = VSQ_W'(in_sample_value) * VSQ_W'(in_sample_value);
  end

  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_full;
  assign q_item   = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/hrs_queue.sv
module hrs_queue import hrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  hrs_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output hrs_item_t head_item
);

  hrs_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign full       = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (fill_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/hrs_math.sv
module hrs_math import hrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  hrs_stats_t stats,
  output logic       done,
  output hrs_res_t   res
);

  typedef enum logic [2:0] {
    M_IDLE, M_MUL, M_DIFF, M_SQRT, M_LOAD, M_SDIV, M_FIN
  } m_state_t;

  m_state_t               state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [COUNT_BITS-1:0]  n_r;
  logic [COUNT_BITS-1:0]  nmul_r;
  logic [SUM_W-1:0]       smul_r;
  logic [PROD_W-1:0]      a_add_r;
  logic [PROD_W-1:0]      b_add_r;
  logic [PROD_W-1:0]      acc_a_r;
  logic [PROD_W-1:0]      acc_b_r;
  logic [DIVD_W-1:0]      div_q_r;
  logic [COUNT_BITS-1:0]  drem_r;
  logic [RAD_W-1:0]       rad_r;
  logic [SREM_W-1:0]      srem_r;
  logic [ROOT_W-1:0]      root_r;
  logic [RES_W-1:0]       mean_r;

  logic [COUNT_BITS:0]    div_t;
  logic                   div_ge;
  logic [COUNT_BITS-1:0]  drem_nxt;
  logic [DIVD_W-1:0]      div_q_nxt;
  logic [SREM_W:0]        srem_sh;
  logic [SREM_W:0]        trial;
  logic                   sq_ge;
  logic [SREM_W-1:0]      srem_nxt;
  logic [ROOT_W-1:0]      root_nxt;

  function automatic logic [RES_W-1:0] sat16(input logic [DIVD_W-1:0] x);
    logic [RES_W-1:0] r;
    r = (|x[DIVD_W-1:RES_W]) ? '1 : x[RES_W-1:0];
    return r;
  endfunction

  // restoring divide step, shared by mean and std dev
  always_comb begin
    div_t     = {drem_r, div_q_r[DIVD_W-1]};
    div_ge    = (div_t >= {1'b0, n_r});
    drem_nxt  = div_ge ? COUNT_BITS'(div_t - {1'b0, n_r}) : div_t[COUNT_BITS-1:0];
    div_q_nxt = {div_q_r[DIVD_W-2:0], div_ge};
  end

  // digit-by-digit square root step, two radicand bits per cycle
  always_comb begin
    srem_sh  = {srem_r[SREM_W-2:0], rad_r[RAD_W-1:RAD_W-2]};
    trial    = {root_r, 2'b01};
    sq_ge    = (srem_sh >= trial);
    srem_nxt = sq_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], sq_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      case (state_r)
        M_IDLE: begin
          if (start) begin
            n_r <= stats.n;
            if (stats.n == '0) begin
              mean_r  <= '0;
              div_q_r <= '0;
              state_r <= M_FIN;
            end else begin
              nmul_r  <= stats.n;
              a_add_r <= PROD_W'(stats.sumsq);
              smul_r  <= stats.sum;
              b_add_r <= PROD_W'(stats.sum);
              acc_a_r <= '0;
              acc_b_r <= '0;
              div_q_r <= {stats.sum, 4'b0000};
              drem_r  <= '0;
              cnt_r   <= '0;
              state_r <= M_MUL;
            end
          end
        end
        M_MUL: begin
          // n*sumsq and sum*sum shift-add, mean divide alongside
          acc_a_r <= acc_a_r + (nmul_r[0] ? a_add_r : '0);
          acc_b_r <= acc_b_r + (smul_r[0] ? b_add_r : '0);
          nmul_r  <= nmul_r >> 1;
          smul_r  <= smul_r >> 1;
          a_add_r <= a_add_r << 1;
          b_add_r <= b_add_r << 1;
          div_q_r <= div_q_nxt;
          drem_r  <= drem_nxt;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIVD_W - 1)) begin
            state_r <= M_DIFF;
          end
        end
        M_DIFF: begin
          mean_r <= sat16(div_q_r);
          if (acc_b_r <= acc_a_r) begin
            rad_r   <= {acc_a_r - acc_b_r, 8'h00};
            srem_r  <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= M_SQRT;
          end else begin
            div_q_r <= '0;
            state_r <= M_FIN;
          end
        end
        M_SQRT: begin
          rad_r  <= rad_r << 2;
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            state_r <= M_LOAD;
          end
        end
        M_LOAD: begin
          div_q_r <= DIVD_W'(root_r);
          drem_r  <= '0;
          cnt_r   <= '0;
          state_r <= M_SDIV;
        end
        M_SDIV: begin
          div_q_r <= div_q_nxt;
          drem_r  <= drem_nxt;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIVD_W - 1)) begin
            state_r <= M_FIN;
          end
        end
        M_FIN: begin
          state_r <= M_IDLE;
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

  assign done     = (state_r == M_FIN);
  assign res.mean = mean_r;
  assign res.sd   = sat16(div_q_r);

endmodule

FILE: sv/hrs_back.sv
module hrs_back import hrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  hrs_item_t             head_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_class,
  output logic [COUNT_BITS-1:0] out_sample_count,
  output logic [RES_W-1:0]      out_mean_q4,
  output logic [RES_W-1:0]      out_std_dev_q4,
  output logic [BIN_W-1:0]      out_bin_index,
  output logic [COUNT_BITS-1:0] out_bin_count
);

  typedef enum logic [1:0] {B_IDLE, B_RD, B_CALC, B_OUT} b_state_t;

  b_state_t              state_r;
  hrs_item_t             item_r;
  logic [SLOT_N-1:0]     bin_vld_r;
  logic [COUNT_BITS-1:0] cnt_r   [2];
  logic [SUM_W-1:0]      sum_r   [2];
  logic [SQ_W-1:0]       sumsq_r [2];
  logic [COUNT_BITS-1:0] bin_cnt_r;
  hrs_res_t              res_r;

  logic                  out_valid_r;
  logic                  out_cls_r;
  logic [COUNT_BITS-1:0] out_cnt_r;
  logic [RES_W-1:0]      out_mean_r;
  logic [RES_W-1:0]      out_sd_r;
  logic [BIN_W-1:0]      out_bin_r;
  logic [COUNT_BITS-1:0] out_bcnt_r;

  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] bin_old;
  logic [COUNT_BITS-1:0] bin_nxt;
  hrs_stats_t            st_old;
  hrs_stats_t            st_nxt;
  logic [SUM_W-1:0]      v_ext;
  logic [SQ_W-1:0]       vsq_ext;
  logic                  m_start;
  logic                  m_done;
  hrs_res_t              m_res;
  logic                  out_free;

  hrs_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOT_N)) u_bins (
    .clk   (clk),
    .we    (state_r == B_RD),
    .waddr (item_r.slot),
    .wdata (bin_nxt),
    .re    (pop),
    .raddr (head_item.slot),
    .rdata (ram_rdata)
  );

  hrs_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m_start),
    .stats (st_nxt),
    .done  (m_done),
    .res   (m_res)
  );

  assign pop     = (state_r == B_IDLE) && head_valid;
  assign m_start = (state_r == B_RD);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    bin_old = bin_vld_r[item_r.slot] ? ram_rdata : '0;
    v_ext   = SUM_W'(item_r.value);
    vsq_ext = SQ_W'(item_r.vsq);
    st_old.n     = cnt_r[item_r.cls];
    st_old.sum   = sum_r[item_r.cls];
    st_old.sumsq = sumsq_r[item_r.cls];
    st_nxt  = st_old;
    if (item_r.op == OP_ADD) begin
      bin_nxt = (bin_old == COUNT_MAX) ? bin_old : bin_old + 1'b1;
      if (st_old.n != COUNT_MAX) begin
        st_nxt.n     = st_old.n + 1'b1;
        st_nxt.sum   = (st_old.sum > SUM_MAX - v_ext) ? SUM_MAX : st_old.sum + v_ext;
        st_nxt.sumsq = (st_old.sumsq > SQ_MAX - vsq_ext) ? SQ_MAX
                                                        : st_old.sumsq + vsq_ext;
      end
    end else begin
      bin_nxt = (bin_old != '0) ? bin_old - 1'b1 : bin_old;
      if (st_old.n != '0) begin
        st_nxt.n = st_old.n - 1'b1;
        if (st_old.n == COUNT_BITS'(1)) begin
          st_nxt.sum   = '0;
          st_nxt.sumsq = '0;
        end else begin
          st_nxt.sum   = (st_old.sum > v_ext) ? st_old.sum - v_ext : '0;
          st_nxt.sumsq = (st_old.sumsq > vsq_ext) ? st_old.sumsq - vsq_ext : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      bin_vld_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        cnt_r[c]   <= '0;
        sum_r[c]   <= '0;
        sumsq_r[c] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != B_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (head_valid) begin
            item_r  <= head_item;
            state_r <= B_RD;
          end
        end
        B_RD: begin
          bin_vld_r[item_r.slot] <= 1'b1;
          bin_cnt_r              <= bin_nxt;
          cnt_r[item_r.cls]      <= st_nxt.n;
          sum_r[item_r.cls]      <= st_nxt.sum;
          sumsq_r[item_r.cls]    <= st_nxt.sumsq;
          state_r                <= B_CALC;
        end
        B_CALC: begin
          if (m_done) begin
            res_r   <= m_res;
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cls_r   <= item_r.cls;
            out_cnt_r   <= cnt_r[item_r.cls];
            out_mean_r  <= res_r.mean;
            out_sd_r    <= res_r.sd;
            out_bin_r   <= item_r.bin;
            out_bcnt_r  <= bin_cnt_r;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_class        = out_cls_r;
  assign out_sample_count = out_cnt_r;
  assign out_mean_q4      = out_mean_r;
  assign out_std_dev_q4   = out_sd_r;
  assign out_bin_index    = out_bin_r;
  assign out_bin_count    = out_bcnt_r;

  // math result only arrives while an item waits on it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    m_done |-> (state_r == B_CALC))
    else $error("math done outside calc state");

  // a new result carries the class count as it stands
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_cnt_r == cnt_r[out_cls_r]))
    else $error("result count differs from class count");

  // an empty class holds no sums
  a_empty_c0: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] == '0) |-> (sum_r[0] == '0 && sumsq_r[0] == '0))
    else $error("class 0 empty with nonzero sums");

  a_empty_c1: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[1] == '0) |-> (sum_r[1] == '0 && sumsq_r[1] == '0))
    else $error("class 1 empty with nonzero sums");

endmodule

FILE: sv/histogram_running_statistics_core.sv
// the back end handles one item at a time, paced by the serial math unit
//   (skipped for an empty class): 40-step shift-add multiply with mean divide,
//   40-step square root, 40-step divide
// the front stage and a two-item queue keep accepting while the back end works
// reset (rst_n low, synchronous) clears all counts, sums and histogram bins at once;
//   bins use per-entry valid flops, so no clearing pass is needed
module histogram_running_statistics_core import hrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic                  in_stat_class,
  input  logic [VAL_W-1:0]      in_sample_value,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_class,
  output logic [COUNT_BITS-1:0] out_sample_count,
  output logic [RES_W-1:0]      out_mean_q4,
  output logic [RES_W-1:0]      out_std_dev_q4,
  output logic [BIN_W-1:0]      out_bin_index,
  output logic [COUNT_BITS-1:0] out_bin_count
);

  // front to queue
  logic      q_full;
  logic      q_push;
  hrs_item_t q_item;

  // queue to back end
  logic      q_pop;
  logic      q_head_valid;
  hrs_item_t q_head;

  // front: registers the item, works out its bin, slot and square
  hrs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_stat_class   (in_stat_class),
    .in_sample_value (in_sample_value),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  // short queue decoupling classification from the slow update path
  hrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  // back: bin read-modify-write, class sums, mean and std dev, result register
  hrs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_item        (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_class        (out_class),
    .out_sample_count (out_sample_count),
    .out_mean_q4      (out_mean_q4),
    .out_std_dev_q4   (out_std_dev_q4),
    .out_bin_index    (out_bin_index),
    .out_bin_count    (out_bin_count)
  );

endmodule
